// ===== src/cps_pkg.sv =====
package cps_pkg;

  localparam int EPS_W  = 52;
  localparam int MAXT_W = 17;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;

  localparam logic [EPS_W-1:0]  EPS_RST  = EPS_W'(1);
  localparam logic [MAXT_W-1:0] MAXT_RST = MAXT_W'(65536);

  typedef enum logic {
    REG_EPS  = 1'b0,
    REG_MAXT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic vld;
    logic ovf;
  } dstat_t;

endpackage

// ===== src/cps_div.sv =====
module cps_div #(
  parameter int LW = 52,
  parameter int SW = 145
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cps_pkg::dstat_t                  in_stat,
  input  logic [LW-1:0]                    in_rem,
  input  logic [cps_pkg::MAXT_W-1:0]       in_low,
  input  logic [LW-1:0]                    in_len,
  input  logic [SW-1:0]                    in_side,
  output cps_pkg::dstat_t                  out_stat,
  output logic [cps_pkg::MAXT_W-1:0]       out_q,
  output logic [SW-1:0]                    out_side
);
  import cps_pkg::*;

  localparam int QW = MAXT_W;

  dstat_t          stat_r [QW+1];
  logic [LW-1:0]   rem_r  [QW+1];
  logic [QW-1:0]   low_r  [QW+1];
  logic [QW-1:0]   q_r    [QW+1];
  logic [LW-1:0]   len_r  [QW+1];
  logic [SW-1:0]   side_r [QW+1];

  assign stat_r[0] = in_stat;
  assign rem_r[0]  = in_rem;
  assign low_r[0]  = in_low;
  assign q_r[0]    = '0;
  assign len_r[0]  = in_len;
  assign side_r[0] = in_side;

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [LW:0]   r2;
    logic [LW:0]   diff;
    logic          take;
    logic [LW-1:0] rem_nxt;

    always_comb begin
      r2      = {rem_r[g], low_r[g][QW-1]};
      diff    = r2 - {1'b0, len_r[g]};
      take    = (r2 >= {1'b0, len_r[g]});
      rem_nxt = take ? diff[LW-1:0] : r2[LW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stat_r[g+1] <= '0;
      end else begin
        stat_r[g+1] <= stat_r[g];
      end
      rem_r[g+1]  <= rem_nxt;
      low_r[g+1]  <= {low_r[g][QW-2:0], 1'b0};
      q_r[g+1]    <= {q_r[g][QW-2:0], take};
      len_r[g+1]  <= len_r[g];
      side_r[g+1] <= side_r[g];
    end
  end

  assign out_stat = stat_r[QW];
  assign out_q    = q_r[QW];
  assign out_side = side_r[QW];

  a_ovf_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stat.vld |-> ##QW (out_stat.vld && (out_stat.ovf == $past(in_stat.ovf, QW))))
    else $error("divider status lost");
  a_vld_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_stat.vld |-> $past(in_stat.vld, QW))
    else $error("divider result without source");
  a_len_zero_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stat.vld && in_len == '0) |-> in_stat.ovf)
    else $error("zero length not flagged");

endmodule

// ===== src/closest_point_on_segment_3d.sv =====
// Closest point on a 3D segment. One query is taken per clock whenever start is
// high (busy is always low) and its result appears on out_* with out_valid for
// exactly one cycle; the receiver cannot stall, so results must be captured when
// out_valid is high. The pipeline is the bit per stage restoring divider for t
// (one stage per bit of the 17-bit t range) plus difference, product, sum, setup,
// clamp, blend and saturate stages. Registers eps_sq (0x0) and max_t (0x8) must
// be written only while no queries are in flight; the block does not enforce this.
module closest_point_on_segment_3d #(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cps_pkg::ADDR_W-1:0]     paddr,
  input  logic [cps_pkg::DATA_W-1:0]     pwdata,
  output logic [cps_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  in_start_x,
  input  logic signed [COORD_WIDTH-1:0]  in_start_y,
  input  logic signed [COORD_WIDTH-1:0]  in_start_z,
  input  logic signed [COORD_WIDTH-1:0]  in_end_x,
  input  logic signed [COORD_WIDTH-1:0]  in_end_y,
  input  logic signed [COORD_WIDTH-1:0]  in_end_z,
  input  logic signed [COORD_WIDTH-1:0]  in_query_x,
  input  logic signed [COORD_WIDTH-1:0]  in_query_y,
  input  logic signed [COORD_WIDTH-1:0]  in_query_z,
  output logic                           out_valid,
  output logic signed [COORD_WIDTH-1:0]  out_near_x,
  output logic signed [COORD_WIDTH-1:0]  out_near_y,
  output logic signed [COORD_WIDTH-1:0]  out_near_z,
  output logic                           out_degenerate
);
  import cps_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int F    = T_FRAC_BITS;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int LW   = PW + 2;
  localparam int QW   = MAXT_W;
  localparam int NW   = LW + F;
  localparam int RW0  = NW - QW;
  localparam int CMPW = (LW > EPS_W) ? LW : EPS_W;
  localparam int OVW  = (RW0 > LW) ? RW0 : LW;
  localparam int SW   = 6 * CW + 1;
  localparam int AW   = QW + 1;
  localparam int MW   = CW + AW;
  localparam int SUMW = MW + 1;
  localparam int LAT  = QW + 7;

  // configuration
  logic [EPS_W-1:0]  eps_r;
  logic [MAXT_W-1:0] maxt_r;
  logic              wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= EPS_RST;
      maxt_r <= MAXT_RST;
    end else if (wr) begin
      case (reg_idx_t'(paddr[ADDR_W-1]))
        REG_EPS:  eps_r  <= pwdata[EPS_W-1:0];
        REG_MAXT: maxt_r <= pwdata[MAXT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1]))
      REG_EPS:  prdata = DATA_W'(eps_r);
      REG_MAXT: prdata = DATA_W'(maxt_r);
      default:  prdata = '0;
    endcase
  end

  // stage 1: differences
  logic signed [CW-1:0] s_in [3];
  logic signed [CW-1:0] e_in [3];
  logic signed [CW-1:0] q_in [3];

  assign s_in[0] = in_start_x;
  assign s_in[1] = in_start_y;
  assign s_in[2] = in_start_z;
  assign e_in[0] = in_end_x;
  assign e_in[1] = in_end_y;
  assign e_in[2] = in_end_z;
  assign q_in[0] = in_query_x;
  assign q_in[1] = in_query_y;
  assign q_in[2] = in_query_z;

  logic                 s1_vld_r;
  logic signed [DW-1:0] s1_d_r [3];
  logic signed [DW-1:0] s1_p_r [3];
  logic [SW-1:0]        s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    for (int i = 0; i < 3; i++) begin
      s1_d_r[i] <= DW'(e_in[i]) - DW'(s_in[i]);
      s1_p_r[i] <= DW'(q_in[i]) - DW'(s_in[i]);
    end
    s1_side_r <= {1'b0, s_in[0], s_in[1], s_in[2], e_in[0], e_in[1], e_in[2]};
  end

  // stage 2: products
  logic                 s2_vld_r;
  logic signed [PW-1:0] s2_dd_r [3];
  logic signed [PW-1:0] s2_dp_r [3];
  logic [SW-1:0]        s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      s2_dd_r[i] <= s1_d_r[i] * s1_d_r[i];
      s2_dp_r[i] <= s1_d_r[i] * s1_p_r[i];
    end
    s2_side_r <= s1_side_r;
  end

  // stage 3: sums
  logic                 s3_vld_r;
  logic signed [LW-1:0] s3_len_r;
  logic signed [LW-1:0] s3_dot_r;
  logic [SW-1:0]        s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_len_r  <= LW'(s2_dd_r[0]) + LW'(s2_dd_r[1]) + LW'(s2_dd_r[2]);
    s3_dot_r  <= LW'(s2_dp_r[0]) + LW'(s2_dp_r[1]) + LW'(s2_dp_r[2]);
    s3_side_r <= s2_side_r;
  end

  // stage 4: degenerate test and divider setup
  logic [LW-1:0]  len_u;
  logic [LW-1:0]  num;
  logic [NW-1:0]  nsh;
  logic [RW0-1:0] rem0;
  logic           deg;
  logic           ovf;

  always_comb begin
    len_u = s3_len_r;
    num   = (s3_dot_r > 0) ? s3_dot_r : '0;
    nsh   = {num, {F{1'b0}}};
    rem0  = nsh[NW-1:QW];
    deg   = CMPW'(eps_r) >= CMPW'(len_u);
    ovf   = OVW'(rem0) >= OVW'(len_u);
  end

  dstat_t        s4_stat_r;
  logic [LW-1:0] s4_rem_r;
  logic [QW-1:0] s4_low_r;
  logic [LW-1:0] s4_len_r;
  logic [SW-1:0] s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_stat_r <= '0;
    end else begin
      s4_stat_r <= '{vld: s3_vld_r, ovf: ovf};
    end
    s4_rem_r  <= LW'(rem0);
    s4_low_r  <= nsh[QW-1:0];
    s4_len_r  <= len_u;
    s4_side_r <= {deg, s3_side_r[SW-2:0]};
  end

  dstat_t        dv_stat;
  logic [QW-1:0] dv_q;
  logic [SW-1:0] dv_side;

  cps_div #(
    .LW (LW),
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stat  (s4_stat_r),
    .in_rem   (s4_rem_r),
    .in_low   (s4_low_r),
    .in_len   (s4_len_r),
    .in_side  (s4_side_r),
    .out_stat (dv_stat),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // clamp
  logic              c_vld_r;
  logic [QW-1:0]     c_t_r;
  logic [QW-1:0]     c_a_r;
  logic [SW-1:0]     c_side_r;
  logic [QW-1:0]     t_cl;

  assign t_cl = (dv_stat.ovf || dv_q > maxt_r) ? maxt_r : dv_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= dv_stat.vld;
    end
    c_t_r    <= t_cl;
    c_a_r    <= maxt_r - t_cl;
    c_side_r <= dv_side;
  end

  // blend products
  logic                 m_vld_r;
  logic signed [MW-1:0] m_pa_r [3];
  logic signed [MW-1:0] m_pb_r [3];
  logic [SW-1:0]        m_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= c_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      m_pa_r[i] <= $signed({1'b0, c_a_r}) * $signed(c_side_r[(6-i)*CW-1 -: CW]);
      m_pb_r[i] <= $signed({1'b0, c_t_r}) * $signed(c_side_r[(3-i)*CW-1 -: CW]);
    end
    m_side_r <= c_side_r;
  end

  // sum, floor shift, saturate
  logic signed [SUMW-1:0] sum   [3];
  logic signed [SUMW-1:0] sh    [3];
  logic [CW-1:0]          sat   [3];
  logic [CW-1:0]          res   [3];
  logic [SUMW-CW:0]       top   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUMW'(m_pa_r[i]) + SUMW'(m_pb_r[i]);
      sh[i]  = sum[i] >>> F;
      top[i] = sh[i][SUMW-1:CW-1];
      if ((&top[i]) || !(|top[i])) begin
        sat[i] = sh[i][CW-1:0];
      end else if (sh[i][SUMW-1]) begin
        sat[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        sat[i] = {1'b0, {(CW-1){1'b1}}};
      end
      res[i] = m_side_r[SW-1] ? m_side_r[(6-i)*CW-1 -: CW] : sat[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= m_vld_r;
    end
    out_near_x     <= res[0];
    out_near_y     <= res[1];
    out_near_z     <= res[2];
    out_degenerate <= m_side_r[SW-1];
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("transfer lost in pipeline");
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without transfer");
  a_deg_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_near_x == $past(in_start_x, LAT) && out_near_y == $past(in_start_y, LAT) &&
       out_near_z == $past(in_start_z, LAT)))
    else $error("degenerate result differs from start");

endmodule

// ===== tb/tb_closest_point_on_segment_3d.sv =====
`timescale 1ns / 1ps

module tb_closest_point_on_segment_3d;
  import cps_pkg::*;

  localparam int CW  = 24;
  localparam int TFB = 16;
  localparam int LAT = MAXT_W + 7;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez, qx, qy, qz;
  } seg_query_t;

  typedef struct packed {
    logic signed [CW-1:0] nx, ny, nz;
    logic                 degen;
  } near_pt_t;

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;
  logic start, busy;
  seg_query_t q_drv;
  logic out_valid, out_degenerate;
  logic signed [CW-1:0] out_near_x, out_near_y, out_near_z;

  logic [EPS_W-1:0]  eps_cfg;
  logic [MAXT_W-1:0] maxt_cfg;
  near_pt_t near_expq[$];
  int errors;
  int idle_pct;

  closest_point_on_segment_3d DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .in_start_x(q_drv.sx), .in_start_y(q_drv.sy), .in_start_z(q_drv.sz),
    .in_end_x(q_drv.ex), .in_end_y(q_drv.ey), .in_end_z(q_drv.ez),
    .in_query_x(q_drv.qx), .in_query_y(q_drv.qy), .in_query_z(q_drv.qz),
    .out_valid(out_valid), .out_near_x(out_near_x), .out_near_y(out_near_y),
    .out_near_z(out_near_z), .out_degenerate(out_degenerate)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [CW-1:0] blend_coord(logic signed [CW-1:0] s,
      logic signed [CW-1:0] e, logic [MAXT_W-1:0] t);
    logic signed [63:0] acc, v;
    acc = $signed({1'b0, maxt_cfg - t}) * 64'(s) + $signed({1'b0, t}) * 64'(e);
    v = acc >>> TFB;
    if (v > 64'(CMAX)) v = 64'(CMAX);
    if (v < 64'(CMIN)) v = 64'(CMIN);
    return v[CW-1:0];
  endfunction

  function automatic near_pt_t project_point(seg_query_t q);
    logic signed [CW:0] d[3], p[3];
    logic signed [127:0] len, dot, num, quo;
    logic [MAXT_W-1:0] t;
    near_pt_t r;
    d[0] = q.ex - q.sx; d[1] = q.ey - q.sy; d[2] = q.ez - q.sz;
    p[0] = q.qx - q.sx; p[1] = q.qy - q.sy; p[2] = q.qz - q.sz;
    len = 0; dot = 0;
    for (int i = 0; i < 3; i++) begin
      len += 128'(d[i]) * 128'(d[i]);
      dot += 128'(d[i]) * 128'(p[i]);
    end
    if (len <= $signed({76'd0, eps_cfg})) begin
      r.nx = q.sx; r.ny = q.sy; r.nz = q.sz; r.degen = 1'b1;
      return r;
    end
    t = 0;
    if (dot > 0) begin
      num = dot <<< TFB;
      quo = num / len;
      if (quo > $signed({111'd0, maxt_cfg})) t = maxt_cfg;
      else t = quo[MAXT_W-1:0];
    end
    r.nx = blend_coord(q.sx, q.ex, t);
    r.ny = blend_coord(q.sy, q.ey, t);
    r.nz = blend_coord(q.sz, q.ez, t);
    r.degen = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    near_pt_t ex;
    if (rst_n && out_valid) begin
      if (near_expq.size() == 0) begin
        $error("result with no pending query");
        errors++;
      end else begin
        ex = near_expq.pop_front();
        if (out_near_x !== ex.nx) begin
          $error("near_x exp %0d got %0d", ex.nx, out_near_x); errors++;
        end
        if (out_near_y !== ex.ny) begin
          $error("near_y exp %0d got %0d", ex.ny, out_near_y); errors++;
        end
        if (out_near_z !== ex.nz) begin
          $error("near_z exp %0d got %0d", ex.nz, out_near_z); errors++;
        end
        if (out_degenerate !== ex.degen) begin
          $error("degenerate exp %0b got %0b", ex.degen, out_degenerate); errors++;
        end
      end
    end
  end

  task automatic send_query(seg_query_t q);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    q_drv <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    near_expq.push_back(project_point(q));
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (near_expq.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(8 * int'(idx)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_EPS) eps_cfg = val[EPS_W-1:0];
    else maxt_cfg = val[MAXT_W-1:0];
    @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return CMAX;
      1: return CMIN;
      2: return CW'($signed($urandom_range(8000)) - 4000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic seg_query_t rand_query();
    seg_query_t q;
    q = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    if ($urandom_range(9) == 0) begin
      q.ex = q.sx + CW'($urandom_range(2)); q.ey = q.sy; q.ez = q.sz;
    end
    return q;
  endfunction

  task automatic test_directed;
    seg_query_t q;
    q = '0; send_query(q);
    q = '0; q.ex = 24'sd4096; q.qx = 24'sd2048; send_query(q);
    q.qx = -24'sd100; send_query(q);
    q.qx = 24'sd9000; send_query(q);
    q = {CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX}; send_query(q);
    q = {CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN}; send_query(q);
    q = {CMIN, CMAX, 24'sd0, CMAX, CMIN, 24'sd5, 24'sd0, 24'sd0, 24'sd0}; send_query(q);
    q = {24'sd7, 24'sd7, 24'sd7, 24'sd8, 24'sd7, 24'sd7, 24'sd9, 24'sd3, CMIN};
    send_query(q);
    q = {24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd5, CMAX, CMAX, CMAX};
    send_query(q);
    q = {24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd0, 24'sd0};
    send_query(q);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_query(rand_query());
    drain();
  endtask

  task automatic test_config_sweep;
    write_reg(REG_MAXT, 64'd131071); write_reg(REG_EPS, 64'd0);
    test_directed(); test_random(120);
    write_reg(REG_MAXT, 64'd0);
    test_random(80);
    write_reg(REG_EPS, {12'd0, {EPS_W{1'b1}}}); write_reg(REG_MAXT, 64'd65536);
    test_random(60);
    write_reg(REG_EPS, 64'd1 << 30); write_reg(REG_MAXT, 64'd98304);
    test_random(120);
    write_reg(REG_EPS, 64'(EPS_RST)); write_reg(REG_MAXT, 64'(MAXT_RST));
  endtask

  initial begin
    errors = 0; idle_pct = 32;
    eps_cfg = EPS_RST; maxt_cfg = MAXT_RST;
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    start = 0; q_drv = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    idle_pct = 0;
    test_random(200);
    idle_pct = 32;
    test_config_sweep();
    test_random(100);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0 && near_expq.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
